FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the hash unit.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/mm3_pkg.sv
// ----------------------------------------------------------------------------
// mm3_pkg
// Types and constants shared by the MurmurHash3 x86_32 controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mm3_pkg;

  localparam logic [31:0] MixC1  = 32'hcc9e2d51;
  localparam logic [31:0] MixC2  = 32'h1b873593;
  localparam logic [31:0] MixAdd = 32'he6546b64;
  localparam logic [31:0] FinM1  = 32'h85ebca6b;
  localparam logic [31:0] FinM2  = 32'hc2b2ae35;

  localparam logic [2:0] FullCount = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_MIX,
    ST_FIN1,
    ST_FIN2,
    ST_EMIT
  } state_e;

  typedef enum logic [1:0] {
    MUL_KEY1,
    MUL_KEY2,
    MUL_FIN1,
    MUL_FIN2
  } mul_sel_e;

  typedef struct packed {
    logic     load;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     mix;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic cnt_zero;
  } status_t;

endpackage

FILE: rtl/murmur3_32_hash_unit.sv
// ----------------------------------------------------------------------------
// murmur3_32_hash_unit
// MurmurHash3 x86_32 over a message of little-endian 32-bit words.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+----------------------------
//  in       | input     | in_valid_i / in_ready_o   | data_word, byte_count, last
//  out      | output    | out_valid_o / out_ready_i | hash_value
//  seed cfg | input     | seed_we_i                 | seed_i
//
//  A non-last word steps through accept, key multiply by C1, by C2, and fold.
//  A last item adds two finalizer multiplies and the result load;
//  an empty last item skips the C2 multiply and the fold. One multiplier unit.
//  The result register frees the input side; a last item that finishes while
//  the previous result is still pending holds until that transfer completes.
//  Reset clears the seed, the hash state and the output valid flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module murmur3_32_hash_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        seed_we_i,
  input  logic [31:0] seed_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] data_word_i,
  input  logic [2:0]  byte_count_i,
  input  logic        last_word_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] hash_value_o
);
  import mm3_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequencer: walks each item through multiply, mix and finalize steps.
  mm3_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Datapath: seed, running hash, byte count, multiplier, result register.
  mm3_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .seed_we_i    (seed_we_i),
    .seed_i       (seed_i),
    .data_word_i  (data_word_i),
    .byte_count_i (byte_count_i),
    .last_word_i  (last_word_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .hash_value_o (hash_value_o)
  );

  // A transfer into the block makes the sequencer busy next cycle.
  `ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o,
               "accepted item did not start the sequencer")
  // Never overwrite a result that is still waiting.
  `ASSERT_IMPL(a_no_result_overwrite, clk_i, rst_ni, cmd.out_load, !out_valid_o || out_ready_i,
               "result register overwritten while pending")
  // Finalizing runs only on the last item of a message.
  `ASSERT_ALWAYS(a_fin_only_last, clk_i, rst_ni, !(cmd.out_load && !status.last),
                 "result produced for a non-last item")

endmodule

FILE: rtl/mm3_ctrl.sv
// ----------------------------------------------------------------------------
// mm3_ctrl
// Sequencer for the hash unit: steps one item through the shared multiplier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mm3_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  mm3_pkg::status_t status_i,
  output mm3_pkg::cmd_t    cmd_o
);
  import mm3_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_MUL1;
      ST_MUL1: state_d = status_i.cnt_zero ? ST_FIN1 : ST_MUL2;
      ST_MUL2: state_d = ST_MIX;
      ST_MIX:  state_d = status_i.last ? ST_FIN1 : ST_IDLE;
      ST_FIN1: state_d = ST_FIN2;
      ST_FIN2: state_d = ST_EMIT;
      ST_EMIT: if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Commands.
  always_comb begin
    cmd_o         = '0;
    cmd_o.mul_sel = MUL_KEY1;
    in_ready_o    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_MUL1: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_KEY1;
      end
      ST_MUL2: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_KEY2;
      end
      ST_MIX:  cmd_o.mix = 1'b1;
      ST_FIN1: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_FIN1;
      end
      ST_FIN2: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_FIN2;
      end
      ST_EMIT: cmd_o.out_load = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.out_load) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: rtl/mm3_datapath.sv
// ----------------------------------------------------------------------------
// mm3_datapath
// Hash state, byte counter, shared 32x32 multiplier and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mm3_datapath (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             seed_we_i,
  input  logic [31:0]      seed_i,
  input  logic [31:0]      data_word_i,
  input  logic [2:0]       byte_count_i,
  input  logic             last_word_i,
  input  mm3_pkg::cmd_t    cmd_i,
  output mm3_pkg::status_t status_o,
  output logic [31:0]      hash_value_o
);
  import mm3_pkg::*;

  logic [31:0] seed_q;
  logic [31:0] h_q, h_d;
  logic [31:0] len_q, len_d;
  logic        in_msg_q, in_msg_d;
  logic [31:0] acc_q;
  logic [31:0] word_q;
  logic [2:0]  cnt_q;
  logic        last_q;
  logic [31:0] hash_q;

  logic [2:0]  cnt_in;
  logic [31:0] word_in;
  logic [31:0] mul_a, mul_b, mul_p;
  logic [31:0] fin_x, mix_r;

  // Clamp the count and drop unused tail bytes; non-last items count as full.
  always_comb begin
    cnt_in = FullCount;
    if (last_word_i) begin
      cnt_in = byte_count_i;
      if (byte_count_i inside {[3'd5:3'd7]}) cnt_in = FullCount;
    end
    case (cnt_in)
      3'd1:    word_in = {24'd0, data_word_i[7:0]};
      3'd2:    word_in = {16'd0, data_word_i[15:0]};
      3'd3:    word_in = {8'd0, data_word_i[23:0]};
      default: word_in = data_word_i;
    endcase
  end

  assign fin_x = h_q ^ len_q;

  // Shared multiplier, low 32 bits kept.
  always_comb begin
    case (cmd_i.mul_sel)
      MUL_KEY1: begin
        mul_a = word_q;
        mul_b = MixC1;
      end
      MUL_KEY2: begin
        mul_a = {acc_q[16:0], acc_q[31:17]};
        mul_b = MixC2;
      end
      MUL_FIN1: begin
        mul_a = fin_x ^ {16'd0, fin_x[31:16]};
        mul_b = FinM1;
      end
      MUL_FIN2: begin
        mul_a = acc_q ^ {13'd0, acc_q[31:13]};
        mul_b = FinM2;
      end
      default: begin
        mul_a = word_q;
        mul_b = MixC1;
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  // Full block: rotate 13, times five plus constant. Tail: xor only.
  assign mix_r = {h_q[18:0] ^ acc_q[18:0], h_q[31:19] ^ acc_q[31:19]};

  always_comb begin
    h_d      = h_q;
    len_d    = len_q;
    in_msg_d = in_msg_q;
    if (cmd_i.load && !in_msg_q) begin
      h_d      = seed_q;
      len_d    = '0;
      in_msg_d = 1'b1;
    end
    if (cmd_i.mix) begin
      h_d   = (cnt_q == FullCount) ? ({mix_r[29:0], 2'b00} + mix_r + MixAdd)
                                   : (h_q ^ acc_q);
      len_d = len_q + {29'd0, cnt_q};
    end
    if (cmd_i.out_load) begin
      h_d      = '0;
      len_d    = '0;
      in_msg_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q   <= '0;
      h_q      <= '0;
      len_q    <= '0;
      in_msg_q <= 1'b0;
    end else begin
      if (seed_we_i) seed_q <= seed_i;
      h_q      <= h_d;
      len_q    <= len_d;
      in_msg_q <= in_msg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      word_q <= word_in;
      cnt_q  <= cnt_in;
      last_q <= last_word_i;
    end
    if (cmd_i.mul_en) acc_q <= mul_p;
    if (cmd_i.out_load) hash_q <= acc_q ^ {16'd0, acc_q[31:16]};
  end

  assign status_o.last     = last_q;
  assign status_o.cnt_zero = (cnt_q == 3'd0);
  assign hash_value_o      = hash_q;

endmodule

FILE: sim/tb_murmur3_32_hash_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_murmur3_32_hash_unit
// Self-checking bench for the MurmurHash3 x86_32 hash unit. A stimulus table
// covers empty, tail and full-word endings, oversized byte counts and a seed
// change inside an open message. Random messages follow under several seeds.
// Every result is checked against the in-bench hash predictor or a typed table value.
// ----------------------------------------------------------------------------
module tb_murmur3_32_hash_unit;

  // Hash constants for the predictor.
  localparam logic [31:0] KEY_MUL1  = 32'hcc9e2d51;
  localparam logic [31:0] KEY_MUL2  = 32'h1b873593;
  localparam logic [31:0] FOLD_ADD  = 32'he6546b64;
  localparam logic [31:0] AVAL_MUL1 = 32'h85ebca6b;
  localparam logic [31:0] AVAL_MUL2 = 32'hc2b2ae35;
  localparam logic [2:0]  WORD_BYTES = 3'd4;

  localparam int QUIET_CYCLES  = 16;      // worst item latency plus margin
  localparam int LONG_HOLD     = 400;     // receiver hold-off for back-pressure
  localparam int RAND_PHASES   = 4;
  localparam int PHASE_ITEMS   = 175;
  localparam int CYCLE_LIMIT   = 300000;
  localparam int DIR_ROWS      = 23;

  typedef enum logic {ROW_ITEM, ROW_SEED} row_kind_e;

  // One stimulus row: a word transfer or a seed write (seed carried in word).
  typedef struct packed {
    row_kind_e   kind;
    logic [31:0] word;
    logic [2:0]  count;
    logic        last;
    logic        has_typed;
    logic [31:0] typed_hash;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        seed_we = 1'b0;
  logic [31:0] seed_val = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] data_word = '0;
  logic [2:0]  byte_count = '0;
  logic        last_word = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] hash_value;

  // Typed expectation travels with the payload and is held with it.
  logic        row_typed = 1'b0;
  logic [31:0] row_typed_hash = '0;

  // Predictor state.
  logic [31:0] model_seed = '0;
  logic [31:0] model_hash = '0;
  logic [31:0] model_len = '0;
  logic        model_open = 1'b0;
  logic [31:0] pending_hashes[$];

  logic [31:0] digest;
  logic [31:0] want_hash;
  int          miss_count = 0;
  int          cycle_count = 0;
  int          burst_left = 0;

  // Receiver pattern state.
  logic        hold_request = 1'b0;
  logic        hold_done = 1'b0;
  int          hold_left = 0;
  int          seg_left = 0;
  int          seg_mode = 0;

  stim_row_t dir_rows [DIR_ROWS] = '{
    // empty message straight after reset: seed 0, length 0, hash 0
    '{ROW_ITEM, 32'h00000000, 3'd0, 1'b1, 1'b1, 32'h00000000},
    '{ROW_SEED, 32'hffffffff, 3'd0, 1'b0, 1'b0, 32'h0},
    // single full word as the last item, all ones
    '{ROW_ITEM, 32'hffffffff, 3'd4, 1'b1, 1'b0, 32'h0},
    // empty message under the all-ones seed
    '{ROW_ITEM, 32'h00000000, 3'd0, 1'b1, 1'b0, 32'h0},
    // short counts on non-last words are ignored
    '{ROW_ITEM, 32'h12345678, 3'd1, 1'b0, 1'b0, 32'h0},
    '{ROW_ITEM, 32'hdeadbeef, 3'd0, 1'b0, 1'b0, 32'h0},
    // tails of 3, 1 and 2 bytes; junk above the tail must be dropped
    '{ROW_ITEM, 32'ha5a5a5a5, 3'd3, 1'b1, 1'b0, 32'h0},
    '{ROW_ITEM, 32'hffffff11, 3'd1, 1'b1, 1'b0, 32'h0},
    '{ROW_ITEM, 32'hffff2211, 3'd2, 1'b1, 1'b0, 32'h0},
    // oversized counts behave as a full word
    '{ROW_ITEM, 32'h0bad0bad, 3'd5, 1'b1, 1'b0, 32'h0},
    '{ROW_ITEM, 32'h00000000, 3'd6, 1'b1, 1'b0, 32'h0},
    '{ROW_ITEM, 32'hffffffff, 3'd7, 1'b1, 1'b0, 32'h0},
    // seed change while a message is open applies to the next message only
    '{ROW_ITEM, 32'h11111111, 3'd6, 1'b0, 1'b0, 32'h0},
    '{ROW_ITEM, 32'h22222222, 3'd4, 1'b0, 1'b0, 32'h0},
    '{ROW_SEED, 32'h00000000, 3'd0, 1'b0, 1'b0, 32'h0},
    '{ROW_ITEM, 32'h33333333, 3'd2, 1'b1, 1'b0, 32'h0},
    '{ROW_ITEM, 32'h44444444, 3'd4, 1'b0, 1'b0, 32'h0},
    '{ROW_ITEM, 32'h80000000, 3'd4, 1'b0, 1'b0, 32'h0},
    '{ROW_ITEM, 32'h7fffffff, 3'd4, 1'b1, 1'b0, 32'h0},
    '{ROW_SEED, 32'h80000001, 3'd0, 1'b0, 1'b0, 32'h0},
    '{ROW_ITEM, 32'h00000000, 3'd0, 1'b1, 1'b0, 32'h0},
    '{ROW_ITEM, 32'h00000001, 3'd3, 1'b1, 1'b0, 32'h0},
    '{ROW_ITEM, 32'hfffffffe, 3'd1, 1'b1, 1'b0, 32'h0}
  };

  murmur3_32_hash_unit uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .seed_we_i    (seed_we),
    .seed_i       (seed_val),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .data_word_i  (data_word),
    .byte_count_i (byte_count),
    .last_word_i  (last_word),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .hash_value_o (hash_value)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Hash predictor
  // --------------------------------------------------------------------------
  function automatic logic [31:0] scramble_key(input logic [31:0] k);
    logic [31:0] t;
    t = k * KEY_MUL1;
    t = {t[16:0], t[31:17]};   // rotate left 15
    return t * KEY_MUL2;
  endfunction

  function automatic logic [31:0] avalanche_hash(input logic [31:0] h);
    logic [31:0] t;
    t = h ^ (h >> 16);
    t = t * AVAL_MUL1;
    t = t ^ (t >> 13);
    t = t * AVAL_MUL2;
    return t ^ (t >> 16);
  endfunction

  function automatic void fold_word(input logic [31:0] w);
    logic [31:0] t;
    t = model_hash ^ scramble_key(w);
    t = {t[18:0], t[31:19]};   // rotate left 13
    model_hash = t * 32'd5 + FOLD_ADD;
    model_len  = model_len + 32'd4;
  endfunction

  // Absorb one accepted item; return 1 with the digest when it closes a message.
  function automatic bit absorb_item(input logic [31:0] w, input logic [2:0] cnt,
                                     input logic is_last, output logic [31:0] h);
    logic [2:0]  n;
    logic [31:0] tail;
    h = '0;
    if (!model_open) begin
      model_hash = model_seed;
      model_len  = '0;
      model_open = 1'b1;
    end
    if (!is_last) begin
      fold_word(w);
      return 1'b0;
    end
    n = (cnt > WORD_BYTES) ? WORD_BYTES : cnt;
    if (n == WORD_BYTES) begin
      fold_word(w);
    end else if (n != 3'd0) begin
      case (n)
        3'd1:    tail = {24'd0, w[7:0]};
        3'd2:    tail = {16'd0, w[15:0]};
        default: tail = {8'd0, w[23:0]};
      endcase
      model_hash = model_hash ^ scramble_key(tail);
      model_len  = model_len + {29'd0, n};
    end
    h = avalanche_hash(model_hash ^ model_len);
    model_open = 1'b0;
    model_hash = '0;
    model_len  = '0;
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Monitor: sample both channels and the seed port at each rising edge.
  // Check the result first, then update the predictor.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        if (pending_hashes.size() == 0) begin
          miss_count++;
          if (miss_count <= 10)
            $display("unexpected hash %08h with nothing pending", hash_value);
        end else begin
          want_hash = pending_hashes.pop_front();
          if (hash_value !== want_hash) begin
            miss_count++;
            if (miss_count <= 10)
              $display("hash mismatch: expected %08h, got %08h", want_hash, hash_value);
          end
        end
      end
      if (seed_we)
        model_seed = seed_val;
      if (in_valid && in_ready) begin
        if (absorb_item(data_word, byte_count, last_word, digest))
          pending_hashes.push_back(row_typed ? row_typed_hash : digest);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random segments of always-ready, coin-flip and mostly-stalled
  // patterns; one long hold-off on request so the unit backs up.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_request && !hold_done) begin
      out_ready <= 1'b0;
      hold_left <= LONG_HOLD;
      hold_done <= 1'b1;
    end else begin
      if (seg_left == 0) begin
        seg_mode <= $urandom_range(0, 2);
        seg_left <= $urandom_range(10, 60);
      end else begin
        seg_left <= seg_left - 1;
      end
      case (seg_mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= 1'($urandom_range(0, 1));
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Stop a hung run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sender tasks
  // --------------------------------------------------------------------------

  // Offer one word and hold it until the transfer. Insert a random gap at the
  // start of each burst; otherwise keep valid high across back-to-back words.
  task automatic offer_word(input logic [31:0] w, input logic [2:0] cnt,
                            input logic is_last, input logic typed,
                            input logic [31:0] typed_hash);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 30) : $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    burst_left--;
    in_valid       <= 1'b1;
    data_word      <= w;
    byte_count     <= cnt;
    last_word      <= is_last;
    row_typed      <= typed;
    row_typed_hash <= typed_hash;
    do @(posedge clk_i); while (!in_ready);
  endtask

  // Drop valid and wait until every pending hash is out, then let any
  // trailing non-last word finish its fold.
  task automatic drain_unit();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending_hashes.size() != 0) @(posedge clk_i);
    repeat (QUIET_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_seed(input logic [31:0] s);
    seed_we  <= 1'b1;
    seed_val <= s;
    @(posedge clk_i);
    seed_we  <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int          words_left;
    int          sent;
    int          pick;
    logic [31:0] w;
    logic [2:0]  cnt;
    logic        is_last;
    logic [31:0] phase_seed;

    words_left = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table.
    for (int r = 0; r < DIR_ROWS; r++) begin
      if (dir_rows[r].kind == ROW_SEED) begin
        drain_unit();
        write_seed(dir_rows[r].word);
      end else begin
        offer_word(dir_rows[r].word, dir_rows[r].count, dir_rows[r].last,
                   dir_rows[r].has_typed, dir_rows[r].typed_hash);
      end
    end

    // Random messages, one seed per phase. A message may straddle a phase
    // boundary, so the seed also changes inside open messages.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      drain_unit();
      case (ph)
        0:       phase_seed = 32'h00000000;
        1:       phase_seed = 32'hffffffff;
        default: phase_seed = $urandom();
      endcase
      write_seed(phase_seed);
      if (ph == 1)
        hold_request <= 1'b1;
      sent = 0;
      while (sent < PHASE_ITEMS || (ph == RAND_PHASES - 1 && words_left != 0)) begin
        if (words_left == 0) begin
          pick = $urandom_range(0, 99);
          if (pick < 70)
            words_left = $urandom_range(1, 4);
          else if (pick < 95)
            words_left = $urandom_range(5, 12);
          else
            words_left = $urandom_range(13, 40);
        end
        is_last = (words_left == 1);
        w = $urandom();
        if (is_last)
          cnt = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(5, 7))
                                            : 3'($urandom_range(0, 4));
        else
          cnt = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(0, 7)) : WORD_BYTES;
        offer_word(w, cnt, is_last, 1'b0, 32'h0);
        words_left--;
        sent++;
      end
    end

    drain_unit();
    repeat (QUIET_CYCLES) @(posedge clk_i);

    if (miss_count == 0 && pending_hashes.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
